@@ design/char_lcd_nibble_interface_defines.svh @@
// assertion macros shared by the rtl files
`ifndef CHAR_LCD_NIBBLE_INTERFACE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property checked every clock edge outside reset
`define LCDNIB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("lcdnib assertion failed");

// property checked every clock edge, reset included
`define LCDNIB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("lcdnib assertion failed");

`else

`define LCDNIB_ASSERT(lbl, clk, rstn, prop)
`define LCDNIB_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ design/lcdnib_pkg.sv @@
package lcdnib_pkg;

    // request kinds on s_tuser
    typedef enum logic [1:0] {
        CMD_INSTR = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_INIT  = 2'd2
    } cmd_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PULSE   = 2'd0,
        CFG_STARTUP = 2'd1,
        CFG_SETTLE  = 2'd2
    } cfg_idx_t;

    localparam int IDX_W   = 4;
    localparam int HOLD_W  = 9;
    localparam logic [IDX_W-1:0] INIT_LAST    = 4'd10;
    localparam logic [IDX_W-1:0] STARTUP_CNT  = 4'd4;
    localparam logic [1:0]       PHASE_LAST   = 2'd3;

    // one queued request
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] value;
    } req_t;

    typedef struct packed {
        logic [7:0] pulse_ms;
        logic [7:0] startup_gap_ms;
        logic [7:0] settle_ms;
    } cfg_t;

    // power-up command list
    function automatic logic [7:0] init_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h03;
            4'd1:    b = 8'h03;
            4'd2:    b = 8'h03;
            4'd3:    b = 8'h03;
            4'd4:    b = 8'h02;
            4'd5:    b = 8'h28;
            4'd6:    b = 8'h08;
            4'd7:    b = 8'h01;
            4'd8:    b = 8'h06;
            4'd9:    b = 8'h03;
            4'd10:   b = 8'h0C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ design/lcdnib_front.sv @@
module lcdnib_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          s_tuser,   // [1:0] cmd
    input  logic [7:0]          s_tdata,   // [7:0] byte_value
    output logic                req_valid,
    input  logic                req_ready,
    output lcdnib_pkg::req_t    req
);

    logic             hold_valid_reg, hold_valid_next;
    lcdnib_pkg::req_t hold_req_reg, hold_req_next;
    logic             keep;
    lcdnib_pkg::req_t classified;
    logic             accept;

    assign s_tready  = !hold_valid_reg || req_ready;
    assign accept    = s_tvalid && s_tready;
    assign req_valid = hold_valid_reg;
    assign req       = hold_req_reg;

    always_comb begin
        keep               = 1'b1;
        classified.is_init = 1'b0;
        classified.rs      = 1'b0;
        classified.value   = s_tdata;
        case (lcdnib_pkg::cmd_t'(s_tuser))
            lcdnib_pkg::CMD_INSTR: classified.rs = 1'b0;
            lcdnib_pkg::CMD_DATA:  classified.rs = 1'b1;
            lcdnib_pkg::CMD_INIT:  classified.is_init = 1'b1;
            // unused code is taken and dropped
            default:               keep = 1'b0;
        endcase
    end

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_req_next   = hold_req_reg;
        if (accept) begin
            hold_valid_next = keep;
            hold_req_next   = classified;
        end else if (req_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_req_reg <= hold_req_next;
    end

endmodule

@@ design/lcdnib_queue.sv @@
`include "char_lcd_nibble_interface_defines.svh"

module lcdnib_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  lcdnib_pkg::req_t    push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output lcdnib_pkg::req_t    pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    lcdnib_pkg::req_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign push_ready = count_reg < FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `LCDNIB_ASSERT(a_queue_bound, aclk, aresetn, count_reg <= FULL_CNT)
    `LCDNIB_ASSERT(a_queue_ptrs, aclk, aresetn,
        (count_reg == '0 || count_reg == FULL_CNT) || (wr_ptr_reg != rd_ptr_reg))

endmodule

@@ design/lcdnib_back.sv @@
`include "char_lcd_nibble_interface_defines.svh"

module lcdnib_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  lcdnib_pkg::cfg_t    cfg,
    input  logic                req_valid,
    output logic                req_ready,
    input  lcdnib_pkg::req_t    req,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [0] reg_select, [4:1] nibble, [5] enable,
                                           // [14:6] hold_ms, [15] zero
    output logic                m_tlast    // last
);

    localparam int IW = lcdnib_pkg::IDX_W;
    localparam int HW = lcdnib_pkg::HOLD_W;

    logic             busy_reg, busy_next;
    lcdnib_pkg::req_t cur_reg, cur_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [1:0]       phase_reg, phase_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_rs_reg, out_rs_next;
    logic [3:0]       out_nib_reg, out_nib_next;
    logic             out_en_reg, out_en_next;
    logic [HW-1:0]    out_hold_reg, out_hold_next;
    logic             out_last_reg, out_last_next;

    logic             advance, final_step, pop;
    logic [7:0]       cur_byte, extra;

    assign advance    = busy_reg && (!out_valid_reg || m_tready);
    assign final_step = (phase_reg == lcdnib_pkg::PHASE_LAST)
                        && (!cur_reg.is_init || idx_reg == lcdnib_pkg::INIT_LAST);
    assign req_ready  = !busy_reg || (advance && final_step);
    assign pop        = req_valid && req_ready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_hold_reg, out_en_reg, out_nib_reg, out_rs_reg};
    assign m_tlast  = out_last_reg;

    // pin levels for the current step
    always_comb begin
        cur_byte = cur_reg.is_init ? lcdnib_pkg::init_byte(idx_reg) : cur_reg.value;
        extra    = 8'd0;
        if (cur_reg.is_init && idx_reg < lcdnib_pkg::STARTUP_CNT) begin
            extra = cfg.startup_gap_ms;
        end else if (cur_reg.is_init && idx_reg == lcdnib_pkg::INIT_LAST) begin
            extra = cfg.settle_ms;
        end
        out_rs_next   = cur_reg.is_init ? 1'b0 : cur_reg.rs;
        out_nib_next  = phase_reg[1] ? cur_byte[3:0] : cur_byte[7:4];
        out_en_next   = !phase_reg[0];
        // gap only on the falling edge that ends a byte
        out_hold_next = {1'b0, cfg.pulse_ms}
                        + ((phase_reg == lcdnib_pkg::PHASE_LAST) ? {1'b0, extra} : '0);
        out_last_next = final_step;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        busy_next  = busy_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        if (pop) begin
            busy_next  = 1'b1;
            cur_next   = req;
            idx_next   = '0;
            phase_next = '0;
        end else if (advance && final_step) begin
            busy_next = 1'b0;
        end else if (advance) begin
            phase_next = phase_reg + 1'b1;
            if (phase_reg == lcdnib_pkg::PHASE_LAST) begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (advance) begin
            out_rs_reg   <= out_rs_next;
            out_nib_reg  <= out_nib_next;
            out_en_reg   <= out_en_next;
            out_hold_reg <= out_hold_next;
            out_last_reg <= out_last_next;
        end
    end

    `LCDNIB_ASSERT(a_idx_range, aclk, aresetn,
        !busy_reg || idx_reg <= lcdnib_pkg::INIT_LAST)
    `LCDNIB_ASSERT(a_last_low, aclk, aresetn,
        (m_tvalid && m_tlast) |-> !out_en_reg)
    `LCDNIB_ASSERT(a_pop_busy, aclk, aresetn, pop |=> busy_reg)
    `LCDNIB_ASSERT(a_byte_idx0, aclk, aresetn,
        (busy_reg && !cur_reg.is_init) |-> idx_reg == '0)

endmodule

@@ design/char_lcd_nibble_interface.sv @@
// channel  | dir | handshake            | payload
// s_       | in  | s_tvalid / s_tready  | s_tuser[1:0] cmd, s_tdata[7:0] byte_value
// m_       | out | m_tvalid / m_tready  | m_tdata reg_select,nibble,enable,hold_ms; m_tlast
// cfg_     | in  | cfg_valid / cfg_ready| cfg_index[1:0], cfg_data[7:0]
//
// a command or data request gives 4 beats on m_, the init request 44, one beat per cycle
// while m_tready is high, from the back sequencer's single output register; requests
// enter at up to one per cycle; reset (aresetn low, synchronous) empties the front
// register and queue and sets pulse_ms 1, startup_gap_ms 4, settle_ms 20
// m_tready low freezes the sequencer; the front register and QUEUE_DEPTH queue entries
// keep taking requests until full, then s_tready drops
module char_lcd_nibble_interface #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,    // [1:0] cmd
    input  logic [7:0]  s_tdata,    // [7:0] byte_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [0] reg_select, [4:1] nibble, [5] enable,
                                    // [14:6] hold_ms, [15] zero
    output logic        m_tlast,    // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    lcdnib_pkg::cfg_t cfg_reg, cfg_next;
    logic             f_valid, f_ready;
    lcdnib_pkg::req_t f_req;
    logic             q_valid, q_ready;
    lcdnib_pkg::req_t q_req;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (lcdnib_pkg::cfg_idx_t'(cfg_index))
                lcdnib_pkg::CFG_PULSE:   cfg_next.pulse_ms       = cfg_data;
                lcdnib_pkg::CFG_STARTUP: cfg_next.startup_gap_ms = cfg_data;
                lcdnib_pkg::CFG_SETTLE:  cfg_next.settle_ms      = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_ms       <= 8'd1;
            cfg_reg.startup_gap_ms <= 8'd4;
            cfg_reg.settle_ms      <= 8'd20;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lcdnib_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .req_valid (f_valid),
        .req_ready (f_ready),
        .req       (f_req)
    );

    lcdnib_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_req),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_req)
    );

    lcdnib_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .req_valid (q_valid),
        .req_ready (q_ready),
        .req       (q_req),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
